// ----- rtl/iase_pkg.sv -----
// ----------------------------------------------------------------------------
// iase_pkg: shared types and constants
// Operation and status codes, sequencer states and default sizes for the
// indexed array (insert / erase / resize) core.
// ----------------------------------------------------------------------------
package iase_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    // Field widths of the beat payloads
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 5;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 5;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_RESIZE = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_MVRD = 8'b0000_0100,
        S_MVWR = 8'b0000_1000,
        S_PUT  = 8'b0001_0000,
        S_FILL = 8'b0010_0000,
        S_ENDS = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

endpackage

// ----- rtl/indexed_array_shift_insert_erase_core.sv -----
// ----------------------------------------------------------------------------
// indexed_array_shift_insert_erase_core
// Bounded ordered array of words held in a synchronous RAM, with read,
// append, insert, erase, remove-last and resize operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one operation per beat: i_func,
//   i_index, i_value, i_new_length. Output channel (o_valid / i_ready) returns
//   one result beat per operation: status, word read, new length, first and
//   last element. Operations run one at a time through a sequencer around a
//   RAM with one write port and two registered read ports.
//   Append, remove last, a resize that does not grow, errors and unused codes
//   go straight to the end reads and the final state; a read passes through
//   the read state first; insert and erase move each shifted element with a
//   RAM read and a write-back (insert then writes the new word); a resize
//   that grows writes zero into each new slot. The sequencer returns to idle,
//   ready for the next input beat, at the edge that registers the result.
//   The result sits in an output register, so a new beat is accepted while
//   the previous result waits; a stalled receiver holds the sequencer in its
//   final state once that register is full. Reset empties the array at once
//   (length zero, no RAM clearing pass).
// ----------------------------------------------------------------------------
module indexed_array_shift_insert_erase_core #(
    parameter int CAPACITY  = iase_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = iase_pkg::WORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic        [iase_pkg::FUNC_W-1:0]   i_func,
    input  logic        [iase_pkg::INDEX_W-1:0]  i_index,
    input  logic signed [iase_pkg::VALUE_W-1:0]  i_value,
    input  logic        [iase_pkg::LENGTH_W-1:0] i_new_length,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic        [iase_pkg::STATUS_W-1:0] o_status,
    output logic signed [iase_pkg::VALUE_W-1:0]  o_read_word,
    output logic        [iase_pkg::LENGTH_W-1:0] o_length,
    output logic signed [iase_pkg::VALUE_W-1:0]  o_first_word,
    output logic signed [iase_pkg::VALUE_W-1:0]  o_last_word
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = ((CW > iase_pkg::INDEX_W) ? CW : iase_pkg::INDEX_W) + 1;
    localparam int XW = (WORD_BITS > iase_pkg::VALUE_W) ? WORD_BITS : iase_pkg::VALUE_W;
    localparam int VW = iase_pkg::VALUE_W;

    // Element RAM
    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] r_rdata_a;
    logic [WORD_BITS-1:0] r_rdata_b;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;

    // Sequencer and operation registers
    iase_pkg::t_state              r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_ptr, n_ptr;
    logic [iase_pkg::FUNC_W-1:0]   r_func;
    logic [AW-1:0]                 r_idx;
    logic [WORD_BITS-1:0]          r_val;
    logic [iase_pkg::STATUS_W-1:0] r_status;

    // Result registers
    logic                          r_out_valid;
    logic [iase_pkg::STATUS_W-1:0] r_out_status;
    logic [VW-1:0]                 r_rd;
    logic [VW-1:0]                 r_out_rd;
    logic [iase_pkg::LENGTH_W-1:0] r_out_len;
    logic [VW-1:0]                 r_out_first;
    logic [VW-1:0]                 r_out_last;

    logic                          accept;
    logic                          out_load;
    logic [iase_pkg::STATUS_W-1:0] st_new;
    logic [LW-1:0]                 idx_l;
    logic [LW-1:0]                 cnt_l;
    logic [LW-1:0]                 nlen_l;
    logic [LW-1:0]                 cap_l;
    logic [XW-1:0]                 val_x;
    logic [XW-1:0]                 word_a_x;
    logic [XW-1:0]                 word_b_x;

    assign o_ready  = (r_state == iase_pkg::S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == iase_pkg::S_DONE) && (!r_out_valid || i_ready);

    assign idx_l  = LW'(i_index);
    assign cnt_l  = LW'(r_count);
    assign nlen_l = LW'(i_new_length);
    assign cap_l  = LW'(CAPACITY);

    // Words travel as zero-extended unsigned bits between field and RAM width
    assign val_x    = XW'($unsigned(i_value));
    assign word_a_x = XW'(r_rdata_a);
    assign word_b_x = XW'(r_rdata_b);

    always_comb begin
        st_new = iase_pkg::ST_OK;
        unique case (i_func)
            iase_pkg::FN_READ: begin
                if (idx_l >= cnt_l) st_new = iase_pkg::ST_INDEX;
            end
            iase_pkg::FN_APPEND: begin
                if (cnt_l >= cap_l) st_new = iase_pkg::ST_FULL;
            end
            iase_pkg::FN_INSERT: begin
                // bad index wins over full
                if (idx_l > cnt_l)       st_new = iase_pkg::ST_INDEX;
                else if (cnt_l >= cap_l) st_new = iase_pkg::ST_FULL;
            end
            iase_pkg::FN_ERASE: begin
                if (idx_l >= cnt_l) st_new = iase_pkg::ST_INDEX;
            end
            iase_pkg::FN_POP: begin
                if (r_count == '0) st_new = iase_pkg::ST_EMPTY;
            end
            iase_pkg::FN_RESIZE: begin
                if (nlen_l > cap_l) st_new = iase_pkg::ST_FULL;
            end
            default: st_new = iase_pkg::ST_OK;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_val;
        rd_addr_a = r_idx;
        rd_addr_b = AW'(r_count - CW'(1));

        unique case (r_state)
            iase_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = iase_pkg::S_ENDS;
                    if (st_new == iase_pkg::ST_OK) begin
                        case (i_func)
                            iase_pkg::FN_READ: begin
                                n_state = iase_pkg::S_READ;
                            end
                            iase_pkg::FN_APPEND: begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(r_count);
                                mem_wdata = val_x[WORD_BITS-1:0];
                                n_count   = CW'(r_count + CW'(1));
                            end
                            iase_pkg::FN_INSERT: begin
                                n_count = CW'(r_count + CW'(1));
                                if (idx_l == cnt_l) begin
                                    n_state = iase_pkg::S_PUT;
                                end else begin
                                    n_ptr   = CW'(r_count - CW'(1));
                                    n_state = iase_pkg::S_MVRD;
                                end
                            end
                            iase_pkg::FN_ERASE: begin
                                n_count = CW'(r_count - CW'(1));
                                // erasing the last element moves nothing
                                if (idx_l != LW'(r_count - CW'(1))) begin
                                    n_ptr   = CW'(i_index) + CW'(1);
                                    n_state = iase_pkg::S_MVRD;
                                end
                            end
                            iase_pkg::FN_POP: begin
                                n_count = CW'(r_count - CW'(1));
                            end
                            iase_pkg::FN_RESIZE: begin
                                n_count = CW'(i_new_length);
                                if (nlen_l > cnt_l) begin
                                    n_ptr   = r_count;
                                    n_state = iase_pkg::S_FILL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            iase_pkg::S_READ: begin
                rd_addr_a = r_idx;
                n_state   = iase_pkg::S_ENDS;
            end
            iase_pkg::S_MVRD: begin
                rd_addr_a = AW'(r_ptr);
                n_state   = iase_pkg::S_MVWR;
            end
            iase_pkg::S_MVWR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata_a;
                if (r_func == iase_pkg::FN_INSERT) begin
                    // walk down, each element moves up one slot
                    mem_waddr = AW'(r_ptr + CW'(1));
                    if (AW'(r_ptr) == r_idx) begin
                        n_state = iase_pkg::S_PUT;
                    end else begin
                        n_ptr   = CW'(r_ptr - CW'(1));
                        n_state = iase_pkg::S_MVRD;
                    end
                end else begin
                    // erase: walk up, each element moves down one slot
                    mem_waddr = AW'(r_ptr - CW'(1));
                    if (r_ptr == r_count) begin
                        n_state = iase_pkg::S_ENDS;
                    end else begin
                        n_ptr   = CW'(r_ptr + CW'(1));
                        n_state = iase_pkg::S_MVRD;
                    end
                end
            end
            iase_pkg::S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_val;
                n_state   = iase_pkg::S_ENDS;
            end
            iase_pkg::S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_ptr);
                mem_wdata = '0;
                if (CW'(r_ptr + CW'(1)) == r_count) begin
                    n_state = iase_pkg::S_ENDS;
                end else begin
                    n_ptr = CW'(r_ptr + CW'(1));
                end
            end
            iase_pkg::S_ENDS: begin
                rd_addr_a = '0;
                rd_addr_b = AW'(r_count - CW'(1));
                n_state   = iase_pkg::S_DONE;
            end
            iase_pkg::S_DONE: begin
                // keep both end reads steady while the result waits
                rd_addr_a = '0;
                rd_addr_b = AW'(r_count - CW'(1));
                if (out_load) n_state = iase_pkg::S_IDLE;
            end
            default: n_state = iase_pkg::S_IDLE;
        endcase
    end

    // RAM: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata_a <= mem[rd_addr_a];
        r_rdata_b <= mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iase_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (accept) begin
            r_func   <= i_func;
            r_idx    <= AW'(i_index);
            r_val    <= val_x[WORD_BITS-1:0];
            r_status <= st_new;
        end
        if (r_state == iase_pkg::S_ENDS) begin
            // read data from the read state is still on port A this cycle
            if (r_func == iase_pkg::FN_READ && r_status == iase_pkg::ST_OK) begin
                r_rd <= word_a_x[VW-1:0];
            end else begin
                r_rd <= '0;
            end
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_rd     <= r_rd;
            r_out_len    <= iase_pkg::LENGTH_W'(r_count);
            r_out_first  <= (r_count == '0) ? '0 : word_a_x[VW-1:0];
            r_out_last   <= (r_count == '0) ? '0 : word_b_x[VW-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_word  = r_out_rd;
    assign o_length     = r_out_len;
    assign o_first_word = r_out_first;
    assign o_last_word  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= cap_l)
        else $error("element count beyond capacity");

    a_move_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iase_pkg::S_MVRD || r_state == iase_pkg::S_MVWR ||
         r_state == iase_pkg::S_FILL) |-> (LW'(r_ptr) < cap_l))
        else $error("move pointer outside the array");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("sequencer did not leave idle after an input beat");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iase_pkg::S_DONE && n_state == iase_pkg::S_IDLE) |=> o_valid)
        else $error("result not presented when the operation finished");
`endif

endmodule

// ----- sim/indexed_array_shift_insert_erase_core_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_array_shift_insert_erase_core_tb
// Self-checking bench for the bounded word array core. A scoreboard keeps
// its own copy of the array, works out the result beat of every accepted
// operation and compares it field by field with what the core returns.
// Directed boundary cases come first, then random traffic that drifts the
// length between empty and full. The sender runs in bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module indexed_array_shift_insert_erase_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP      = iase_pkg::CAPACITY_DEF;
    localparam int N_RANDOM = 1850;
    localparam int LIMIT    = 800000;
    localparam int TAIL     = 40;

    // codes the core treats as no-ops
    localparam logic [iase_pkg::FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [iase_pkg::FUNC_W-1:0] FN_SPARE7 = 3'd7;

    typedef logic signed [iase_pkg::VALUE_W-1:0] t_word;
    typedef logic [iase_pkg::FUNC_W-1:0]         t_func;
    typedef logic [iase_pkg::INDEX_W-1:0]        t_index;
    typedef logic [iase_pkg::LENGTH_W-1:0]       t_len;

    typedef struct packed {
        logic [iase_pkg::STATUS_W-1:0] status;
        t_word                         read_word;
        t_len                          length;
        t_word                         first_word;
        t_word                         last_word;
    } t_outcome;

    class t_scoreboard;
        t_word    vec_words[CAP];
        int       vec_len;
        t_outcome outcome_q[$];
        int       mismatches;
        int       checked;
        int       full_hits;

        function new();
            vec_len    = 0;
            mismatches = 0;
            checked    = 0;
            full_hits  = 0;
            foreach (vec_words[i]) vec_words[i] = '0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // apply one accepted operation to the shadow array, queue its result
        function void note_op(t_func fn, t_index idx, t_word val, t_len nl);
            t_outcome r;
            int       n;
            int       i;
            r.status    = iase_pkg::ST_OK;
            r.read_word = '0;
            n = vec_len;
            case (fn)
                iase_pkg::FN_READ: begin
                    if (idx >= n) r.status = iase_pkg::ST_INDEX;
                    else r.read_word = vec_words[idx];
                end
                iase_pkg::FN_APPEND: begin
                    if (n >= CAP) begin
                        r.status = iase_pkg::ST_FULL;
                    end else begin
                        vec_words[n] = val;
                        vec_len = n + 1;
                    end
                end
                iase_pkg::FN_INSERT: begin
                    // bad position wins over a full array
                    if (idx > n) begin
                        r.status = iase_pkg::ST_INDEX;
                    end else if (n >= CAP) begin
                        r.status = iase_pkg::ST_FULL;
                    end else begin
                        for (i = n; i > idx; i--) vec_words[i] = vec_words[i-1];
                        vec_words[idx] = val;
                        vec_len = n + 1;
                    end
                end
                iase_pkg::FN_ERASE: begin
                    if (idx >= n) begin
                        r.status = iase_pkg::ST_INDEX;
                    end else begin
                        for (i = idx; i + 1 < n; i++) vec_words[i] = vec_words[i+1];
                        vec_len = n - 1;
                    end
                end
                iase_pkg::FN_POP: begin
                    if (n == 0) r.status = iase_pkg::ST_EMPTY;
                    else vec_len = n - 1;
                end
                iase_pkg::FN_RESIZE: begin
                    if (nl > CAP) begin
                        r.status = iase_pkg::ST_FULL;
                    end else begin
                        for (i = n; i < nl; i++) vec_words[i] = '0;
                        vec_len = nl;
                    end
                end
                default: ;
            endcase
            if (r.status == iase_pkg::ST_FULL || vec_len == CAP) full_hits++;
            r.length     = vec_len[iase_pkg::LENGTH_W-1:0];
            r.first_word = (vec_len == 0) ? '0 : vec_words[0];
            r.last_word  = (vec_len == 0) ? '0 : vec_words[vec_len-1];
            outcome_q = {outcome_q, r};
        endfunction

        function void flag(string what, logic [31:0] e, logic [31:0] g);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result %0d: %s expected %0h got %0h",
                         $realtime, checked, what, e, g);
        endfunction

        function void check_outcome(t_outcome got);
            t_outcome e;
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result beat with no operation outstanding",
                             $realtime);
                return;
            end
            e = outcome_q.pop_front();
            checked++;
            if (got.status !== e.status)         flag("status", e.status, got.status);
            if (got.read_word !== e.read_word)   flag("read_word", e.read_word, got.read_word);
            if (got.length !== e.length)         flag("length", e.length, got.length);
            if (got.first_word !== e.first_word) flag("first_word", e.first_word, got.first_word);
            if (got.last_word !== e.last_word)   flag("last_word", e.last_word, got.last_word);
        endfunction
    endclass

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_valid      = 1'b0;
    t_func                         i_func       = '0;
    t_index                        i_index      = '0;
    t_word                         i_value      = '0;
    t_len                          i_new_length = '0;
    logic                          i_ready      = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic [iase_pkg::STATUS_W-1:0] o_status;
    t_word                         o_read_word;
    t_len                          o_length;
    t_word                         o_first_word;
    t_word                         o_last_word;

    t_scoreboard sb = new();
    int op_hits[8];
    int cycles = 0;
    int rx_left = 0;
    int rx_mode = 0;
    bit grow_phase = 1'b1;

    indexed_array_shift_insert_erase_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_new_length (i_new_length),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_read_word  (o_read_word),
        .o_length     (o_length),
        .o_first_word (o_first_word),
        .o_last_word  (o_last_word)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("indexed_array_shift_insert_erase_core_tb NOT OK");
            $finish;
        end
    end

    // receiver: runs of always-ready, coin-flip and mostly-stalled
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(1, 40);
        end
        rx_left--;
        case (rx_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_outcome({o_status, o_read_word, o_length, o_first_word, o_last_word});
    end

    // hold one beat on the input until accepted, then record it
    task automatic send_op(input t_func fn, input t_index idx,
                           input t_word val, input t_len nl);
        i_valid      <= 1'b1;
        i_func       <= fn;
        i_index      <= idx;
        i_value      <= val;
        i_new_length <= nl;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_op(fn, idx, val, nl);
        op_hits[fn]++;
    endtask

    task automatic idle(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return t_word'($urandom);
        endcase
    endfunction

    // random op; the length drifts toward full, then toward empty
    task automatic random_op();
        t_func  fn;
        t_index idx;
        t_len   nl;
        int     roll;
        int     len;
        len = sb.vec_len;
        if (len == CAP) grow_phase = 1'b0;
        else if (len == 0) grow_phase = 1'b1;
        else if ($urandom_range(0, 49) == 0) grow_phase = ~grow_phase;
        roll = $urandom_range(0, 99);
        if (grow_phase) begin
            if (roll < 35)      fn = iase_pkg::FN_APPEND;
            else if (roll < 60) fn = iase_pkg::FN_INSERT;
            else if (roll < 75) fn = iase_pkg::FN_READ;
            else if (roll < 84) fn = iase_pkg::FN_ERASE;
            else if (roll < 90) fn = iase_pkg::FN_POP;
            else if (roll < 97) fn = iase_pkg::FN_RESIZE;
            else                fn = (roll < 99) ? FN_SPARE6 : FN_SPARE7;
        end else begin
            if (roll < 30)      fn = iase_pkg::FN_ERASE;
            else if (roll < 55) fn = iase_pkg::FN_POP;
            else if (roll < 72) fn = iase_pkg::FN_READ;
            else if (roll < 80) fn = iase_pkg::FN_APPEND;
            else if (roll < 88) fn = iase_pkg::FN_INSERT;
            else if (roll < 97) fn = iase_pkg::FN_RESIZE;
            else                fn = (roll < 99) ? FN_SPARE6 : FN_SPARE7;
        end
        if ($urandom_range(0, 4) == 0) idx = iase_pkg::INDEX_W'($urandom_range(0, 31));
        else idx = iase_pkg::INDEX_W'($urandom_range(0, len));
        roll = $urandom_range(0, 9);
        if (roll < 7)       nl = iase_pkg::LENGTH_W'($urandom_range(0, CAP));
        else if (roll == 7) nl = iase_pkg::LENGTH_W'(CAP);
        else                nl = iase_pkg::LENGTH_W'($urandom_range(0, 31));
        send_op(fn, idx, rand_word(), nl);
    endtask

    initial begin
        int burst;
        int k;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle(2);

        // empty-array errors
        send_op(iase_pkg::FN_READ,   5'd0,  32'sd5, 5'd0);
        send_op(iase_pkg::FN_POP,    5'd0,  32'sd0, 5'd0);
        send_op(iase_pkg::FN_ERASE,  5'd0,  32'sd0, 5'd0);
        send_op(iase_pkg::FN_INSERT, 5'd1,  32'sd9, 5'd0);
        // build a short array with extreme words
        send_op(iase_pkg::FN_INSERT, 5'd0,  32'sh8000_0000, 5'd0);
        send_op(iase_pkg::FN_APPEND, 5'd0,  32'sh7fff_ffff, 5'd31);
        send_op(iase_pkg::FN_APPEND, 5'd31, -32'sd1, 5'd0);
        send_op(iase_pkg::FN_INSERT, 5'd1,  32'sh5a5a_a5a5, 5'd0);
        send_op(iase_pkg::FN_READ,   5'd0,  32'sd0, 5'd0);
        send_op(iase_pkg::FN_READ,   5'd3,  32'sd0, 5'd0);
        send_op(iase_pkg::FN_READ,   5'd4,  32'sd0, 5'd0);
        send_op(iase_pkg::FN_ERASE,  5'd1,  32'sd0, 5'd0);
        send_op(iase_pkg::FN_ERASE,  5'd2,  32'sd0, 5'd0);
        drain();
        // grow with zero fill, then hit every full case
        send_op(iase_pkg::FN_RESIZE, 5'd0,  32'sd0, 5'd16);
        send_op(iase_pkg::FN_APPEND, 5'd0,  32'sd77, 5'd0);
        send_op(iase_pkg::FN_INSERT, 5'd3,  32'sd77, 5'd0);
        send_op(iase_pkg::FN_INSERT, 5'd16, 32'sd77, 5'd0);
        send_op(iase_pkg::FN_INSERT, 5'd17, 32'sd77, 5'd0);
        send_op(iase_pkg::FN_RESIZE, 5'd0,  32'sd0, 5'd17);
        send_op(iase_pkg::FN_RESIZE, 5'd0,  32'sd0, 5'd31);
        send_op(iase_pkg::FN_ERASE,  5'd0,  32'sd0, 5'd0);
        send_op(iase_pkg::FN_READ,   5'd14, 32'sd0, 5'd0);
        send_op(FN_SPARE6,           5'd31, -32'sd1, 5'd31);
        send_op(FN_SPARE7,           5'd0,  32'sd0, 5'd0);
        send_op(iase_pkg::FN_RESIZE, 5'd0,  32'sd0, 5'd0);
        drain();

        burst = 0;
        for (k = 0; k < N_RANDOM; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
            end
            burst--;
            random_op();
            if (k % 400 == 399) drain();
        end

        drain();
        repeat (TAIL) @(posedge i_clk);

        $display("%0d ops: rd %0d app %0d ins %0d ers %0d pop %0d rsz %0d nop %0d",
                 op_hits.sum(), op_hits[iase_pkg::FN_READ], op_hits[iase_pkg::FN_APPEND],
                 op_hits[iase_pkg::FN_INSERT], op_hits[iase_pkg::FN_ERASE],
                 op_hits[iase_pkg::FN_POP], op_hits[iase_pkg::FN_RESIZE],
                 op_hits[FN_SPARE6] + op_hits[FN_SPARE7]);
        $display("%0d result beats compared, full array seen %0d times, %0d mismatches",
                 sb.checked, sb.full_hits, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("indexed_array_shift_insert_erase_core_tb OK");
        end else begin
            $display("indexed_array_shift_insert_erase_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/iase_pkg.sv
rtl/indexed_array_shift_insert_erase_core.sv
sim/indexed_array_shift_insert_erase_core_tb.sv
